@@ hdl/lz4bd_pkg.sv @@
// shared types and constants for the lz4 block decompressor
// no dependencies; imported by every module of the block
`default_nettype none

package lz4bd_pkg;

  // history window and length sizing
  localparam int WINDOW_DEPTH = 65536;
  localparam int LENGTH_BITS  = 24;
  localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);

  // queue sizing
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // request function codes
  typedef enum logic [1:0] {
    FN_BEGIN = 2'd0,
    FN_BYTE  = 2'd1,
    FN_TICK  = 2'd2
  } func_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ZERO_OFF     = 3'd1,
    ST_PAST_END     = 3'd2,
    ST_BEFORE_START = 3'd3,
    ST_UNEXPECTED   = 3'd4
  } status_t;

  // decoder phase
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TOKEN     = 3'd1,
    PH_LIT_EXT   = 3'd2,
    PH_LITERALS  = 3'd3,
    PH_OFF_LO    = 3'd4,
    PH_OFF_HI    = 3'd5,
    PH_MATCH_EXT = 3'd6,
    PH_COPY      = 3'd7
  } phase_t;

  // history operation carried to the back end
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_LIT  = 2'd1,
    CMD_COPY = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [7:0]            lit_byte;
    logic [ADDR_BITS-1:0]  dst;
    logic [ADDR_BITS-1:0]  src;
    logic                  block_done;
    logic                  copy_pending;
    status_t               status;
  } cmd_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       block_done;
    logic       copy_pending;
    status_t    status;
  } out_ent_t;

endpackage

`default_nettype wire

@@ hdl/lz4bd_front.sv @@
// front end: accepts requests, runs the token/length/offset parser
// depends on lz4bd_pkg; emits one history command per accepted request
`default_nettype none

module lz4bd_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       in_func,
  input  logic [7:0]                       in_byte,
  input  logic [lz4bd_pkg::LENGTH_BITS-1:0] in_block_length,
  input  logic                             cmdq_full,
  output logic                             cmd_push,
  output lz4bd_pkg::cmd_t                  cmd
);
  import lz4bd_pkg::*;

  localparam int LB = LENGTH_BITS;

  // saturating length add
  function automatic logic [LB-1:0] len_sat_add(input logic [LB-1:0] a, input logic [8:0] b);
    logic [LB:0] s;
    s = {1'b0, a} + (LB + 1)'(b);
    len_sat_add = s[LB] ? {LB{1'b1}} : s[LB-1:0];
  endfunction

  phase_t          phase_r, phase_nxt;
  logic [LB-1:0]   produced_r, produced_nxt;
  logic [LB-1:0]   room_r, room_nxt;
  logic [LB-1:0]   lit_rem_r, lit_rem_nxt;
  logic [LB-1:0]   match_rem_r, match_rem_nxt;
  logic [15:0]     offset_r, offset_nxt;
  logic [3:0]      nibble_r, nibble_nxt;

  logic [31:0]          prod32;
  logic [ADDR_BITS-1:0] dst;
  logic [15:0]          off_hi, off_cur;
  logic [LB-1:0]        mr_base, lit_base, match_len, lit_len, room_dec, lit_dec, mr_dec;
  logic [8:0]           mr_add, lit_add;
  logic                 lit_past, match_past, before_start;

  assign full     = cmdq_full;
  assign cmd_push = push && !cmdq_full;

  // shared length arithmetic
  always_comb begin
    prod32       = 32'(produced_r);
    dst          = prod32[ADDR_BITS-1:0];
    off_hi       = {in_byte, offset_r[7:0]};
    off_cur      = (phase_r == PH_OFF_HI) ? off_hi : offset_r;
    mr_base      = (phase_r == PH_OFF_HI) ? LB'(nibble_r) : match_rem_r;
    mr_add       = (phase_r == PH_MATCH_EXT) ? ({1'b0, in_byte} + 9'd4) : 9'd4;
    match_len    = len_sat_add(mr_base, mr_add);
    lit_base     = (phase_r == PH_TOKEN) ? LB'(in_byte[7:4]) : lit_rem_r;
    lit_add      = (phase_r == PH_LIT_EXT) ? {1'b0, in_byte} : 9'd0;
    lit_len      = len_sat_add(lit_base, lit_add);
    lit_past     = lit_len > room_r;
    match_past   = match_len > room_r;
    before_start = 32'(off_cur) > prod32;
    room_dec     = room_r - LB'(1);
    lit_dec      = lit_rem_r - LB'(1);
    mr_dec       = match_rem_r - LB'(1);
  end

  // parser next state and command
  always_comb begin
    phase_nxt     = phase_r;
    produced_nxt  = produced_r;
    room_nxt      = room_r;
    lit_rem_nxt   = lit_rem_r;
    match_rem_nxt = match_rem_r;
    offset_nxt    = offset_r;
    nibble_nxt    = nibble_r;
    cmd.kind       = CMD_NONE;
    cmd.lit_byte   = in_byte;
    cmd.dst        = dst;
    cmd.src        = dst - offset_r[ADDR_BITS-1:0];
    cmd.block_done = 1'b0;
    cmd.status     = ST_OK;

    case (in_func)
      FN_BEGIN: begin
        produced_nxt  = '0;
        room_nxt      = in_block_length;
        lit_rem_nxt   = '0;
        match_rem_nxt = '0;
        offset_nxt    = '0;
        nibble_nxt    = '0;
        if (in_block_length == '0) begin
          phase_nxt      = PH_IDLE;
          cmd.block_done = 1'b1;
        end else begin
          phase_nxt = PH_TOKEN;
        end
      end
      FN_BYTE: begin
        case (phase_r)
          PH_TOKEN: begin
            nibble_nxt    = in_byte[3:0];
            match_rem_nxt = '0;
            lit_rem_nxt   = lit_len;
            if (in_byte[7:4] == 4'hF) begin
              phase_nxt = PH_LIT_EXT;
            end else if (in_byte[7:4] != 4'h0) begin
              if (lit_past) begin
                phase_nxt  = PH_IDLE;
                cmd.status = ST_PAST_END;
              end else begin
                phase_nxt = PH_LITERALS;
              end
            end else begin
              phase_nxt = PH_OFF_LO;
            end
          end
          PH_LIT_EXT: begin
            lit_rem_nxt = lit_len;
            if (in_byte != 8'hFF) begin
              if (lit_past) begin
                phase_nxt  = PH_IDLE;
                cmd.status = ST_PAST_END;
              end else begin
                phase_nxt = PH_LITERALS;
              end
            end
          end
          PH_LITERALS: begin
            cmd.kind     = CMD_LIT;
            produced_nxt = produced_r + LB'(1);
            room_nxt     = room_dec;
            lit_rem_nxt  = lit_dec;
            if (lit_dec == '0) begin
              if (room_dec == '0) begin
                phase_nxt      = PH_IDLE;
                cmd.block_done = 1'b1;
              end else begin
                phase_nxt = PH_OFF_LO;
              end
            end
          end
          PH_OFF_LO: begin
            offset_nxt = {8'h00, in_byte};
            phase_nxt  = PH_OFF_HI;
          end
          PH_OFF_HI: begin
            offset_nxt = off_hi;
            if (off_hi == 16'h0000) begin
              phase_nxt  = PH_IDLE;
              cmd.status = ST_ZERO_OFF;
            end else if (nibble_r == 4'hF) begin
              match_rem_nxt = LB'(nibble_r);
              phase_nxt     = PH_MATCH_EXT;
            end else begin
              match_rem_nxt = match_len;
              if (match_past) begin
                phase_nxt  = PH_IDLE;
                cmd.status = ST_PAST_END;
              end else if (before_start) begin
                phase_nxt  = PH_IDLE;
                cmd.status = ST_BEFORE_START;
              end else begin
                phase_nxt = PH_COPY;
              end
            end
          end
          PH_MATCH_EXT: begin
            if (in_byte == 8'hFF) begin
              match_rem_nxt = len_sat_add(match_rem_r, {1'b0, in_byte});
            end else begin
              match_rem_nxt = match_len;
              if (match_past) begin
                phase_nxt  = PH_IDLE;
                cmd.status = ST_PAST_END;
              end else if (before_start) begin
                phase_nxt  = PH_IDLE;
                cmd.status = ST_BEFORE_START;
              end else begin
                phase_nxt = PH_COPY;
              end
            end
          end
          default: begin
            // a byte while idle or copying
            cmd.status = ST_UNEXPECTED;
          end
        endcase
      end
      FN_TICK: begin
        if (phase_r == PH_COPY) begin
          cmd.kind      = CMD_COPY;
          produced_nxt  = produced_r + LB'(1);
          room_nxt      = room_dec;
          match_rem_nxt = mr_dec;
          if (mr_dec == '0) begin
            if (room_dec == '0) begin
              phase_nxt      = PH_IDLE;
              cmd.block_done = 1'b1;
            end else begin
              phase_nxt = PH_TOKEN;
            end
          end
        end else begin
          cmd.status = ST_UNEXPECTED;
        end
      end
      default: begin
        cmd.status = ST_UNEXPECTED;
      end
    endcase

    cmd.copy_pending = (phase_nxt == PH_COPY);
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      produced_r  <= '0;
      room_r      <= '0;
      lit_rem_r   <= '0;
      match_rem_r <= '0;
      offset_r    <= '0;
      nibble_r    <= '0;
    end else if (cmd_push) begin
      phase_r     <= phase_nxt;
      produced_r  <= produced_nxt;
      room_r      <= room_nxt;
      lit_rem_r   <= lit_rem_nxt;
      match_rem_r <= match_rem_nxt;
      offset_r    <= offset_nxt;
      nibble_r    <= nibble_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/lz4bd_cmd_queue.sv @@
// short command queue between the parser and the history back end
// depends on lz4bd_pkg for the command type and depth
`default_nettype none

module lz4bd_cmd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lz4bd_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output lz4bd_pkg::cmd_t head
);
  import lz4bd_pkg::*;

  cmd_t                  q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] count_r;
  logic                  do_push, do_pop;

  assign full    = (count_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/lz4bd_back.sv @@
// back end: history window memory, copy forwarding and result queue
// depends on lz4bd_pkg for command and result types
`default_nettype none

module lz4bd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmdq_empty,
  input  lz4bd_pkg::cmd_t     cmdq_head,
  output logic                cmdq_pop,
  input  logic                pop,
  output logic                empty,
  output lz4bd_pkg::out_ent_t out_head
);
  import lz4bd_pkg::*;

  logic [7:0]            hist [WINDOW_DEPTH];
  logic [7:0]            rdata_r;
  logic                  fwd_r;
  logic [7:0]            fwd_data_r;
  logic                  b_v_r;
  cmd_t                  b_cmd_r;
  logic [7:0]            b_data;
  logic                  b_go, b_write, outq_full, do_push, do_pop;
  out_ent_t              b_ent;

  out_ent_t              oq_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUTQ_CNT_W-1:0] count_r;

  // stage control
  assign outq_full = (count_r == OUTQ_CNT_W'(OUTQ_DEPTH));
  assign b_go      = !b_v_r || !outq_full;
  assign cmdq_pop  = b_go && !cmdq_empty;
  assign b_write   = b_v_r && b_go && (b_cmd_r.kind != CMD_NONE);
  assign do_push   = b_v_r && b_go;

  // byte for this stage: literal, forwarded write, or memory read
  always_comb begin
    if (b_cmd_r.kind == CMD_LIT) begin
      b_data = b_cmd_r.lit_byte;
    end else if (fwd_r) begin
      b_data = fwd_data_r;
    end else begin
      b_data = rdata_r;
    end
    b_ent.byte_valid   = (b_cmd_r.kind != CMD_NONE);
    b_ent.out_byte     = (b_cmd_r.kind != CMD_NONE) ? b_data : 8'h00;
    b_ent.block_done   = b_cmd_r.block_done;
    b_ent.copy_pending = b_cmd_r.copy_pending;
    b_ent.status       = b_cmd_r.status;
  end

  // history window: write from the stage, read for the next request
  always_ff @(posedge clk) begin
    if (b_write) begin
      hist[b_cmd_r.dst] <= b_data;
    end
    if (cmdq_pop) begin
      rdata_r <= hist[cmdq_head.src];
    end
  end

  // same-edge write to the read address is bypassed
  always_ff @(posedge clk) begin
    if (cmdq_pop) begin
      fwd_r      <= b_write && (b_cmd_r.dst == cmdq_head.src);
      fwd_data_r <= b_data;
      b_cmd_r    <= cmdq_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_go) begin
      b_v_r <= cmdq_pop;
    end
  end

  // result queue
  assign empty    = (count_r == '0);
  assign out_head = oq_r[rd_ptr_r];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      oq_r[wr_ptr_r] <= b_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/lz4_block_decompressor.sv @@
// lz4 block decompressor: parser front end, command queue, history back end
// each result passes through the command queue, the back-end stage and the result queue
// throughput: one request per cycle while full is low, set by the single write and read port
//   of the history window and the parser updating its state once per request
// reset: synchronous active-low rst_n clears parser state and both queues;
//   the history window is not cleared and needs no clearing pass
`default_nettype none

module lz4_block_decompressor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        in_func,
  input  logic [7:0]                        in_byte,
  input  logic [lz4bd_pkg::LENGTH_BITS-1:0] in_block_length,
  input  logic                              pop,
  output logic                              empty,
  output logic                              out_byte_valid,
  output logic [7:0]                        out_byte,
  output logic                              out_block_done,
  output logic                              out_copy_pending,
  output logic [2:0]                        out_status
);
  import lz4bd_pkg::*;

  cmd_t     cmd, cmdq_head;
  logic     cmd_push, cmdq_full, cmdq_pop, cmdq_empty;
  out_ent_t out_head;

  // request parser
  lz4bd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_func         (in_func),
    .in_byte         (in_byte),
    .in_block_length (in_block_length),
    .cmdq_full       (cmdq_full),
    .cmd_push        (cmd_push),
    .cmd             (cmd)
  );

  // decoupling queue
  lz4bd_cmd_queue u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd),
    .full      (cmdq_full),
    .pop       (cmdq_pop),
    .empty     (cmdq_empty),
    .head      (cmdq_head)
  );

  // history and results
  lz4bd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmdq_empty (cmdq_empty),
    .cmdq_head  (cmdq_head),
    .cmdq_pop   (cmdq_pop),
    .pop        (pop),
    .empty      (empty),
    .out_head   (out_head)
  );

  // result ports
  assign out_byte_valid   = out_head.byte_valid;
  assign out_byte         = out_head.out_byte;
  assign out_block_done   = out_head.block_done;
  assign out_copy_pending = out_head.copy_pending;
  assign out_status       = out_head.status;

endmodule

`default_nettype wire
